### src/rrcq_pkg.sv
package rrcq_pkg;

    localparam logic [1:0] FUNC_ADD     = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_RESOLVE = 2'd2;
    localparam logic [1:0] FUNC_CANCEL  = 2'd3;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_WAITING = 2'd1;
    localparam logic [1:0] ST_READY   = 2'd2;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_TICK_READY = 2'd1;
    localparam logic [1:0] ERR_NONE_READY = 2'd2;
    localparam logic [1:0] ERR_FULL       = 2'd3;

    typedef struct packed {
        logic load;
        logic shift;
        logic tick;
        logic reload;
    } cell_ctrl_t;

endpackage

### src/rrcq_cmd_if.sv
interface rrcq_cmd_if #(
    parameter int TIME_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic [TIME_WIDTH-1:0] wait_time;
    logic [TIME_WIDTH-1:0] delta_time;
    logic                  finished;

    modport source (output valid, func, wait_time, delta_time, finished, input ready);
    modport sink   (input valid, func, wait_time, delta_time, finished, output ready);
endinterface

### src/rrcq_rsp_if.sv
interface rrcq_rsp_if #(
    parameter int ID_WIDTH   = 32,
    parameter int SIZE_WIDTH = 5
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [1:0]            error;
    logic [ID_WIDTH-1:0]   new_task_id;
    logic [ID_WIDTH-1:0]   ready_task_id;
    logic [SIZE_WIDTH-1:0] queue_size;

    modport source (output valid, status, error, new_task_id, ready_task_id, queue_size,
                    input ready);
    modport sink   (input valid, status, error, new_task_id, ready_task_id, queue_size,
                    output ready);
endinterface

### src/rrcq_cell.sv
module rrcq_cell #(
    parameter int TIME_WIDTH = 32,
    parameter int ID_WIDTH   = 32
) (
    input  logic                   clk,
    input  rrcq_pkg::cell_ctrl_t   ctrl,
    input  logic [ID_WIDTH-1:0]    new_id,
    input  logic [TIME_WIDTH-1:0]  wait_time,
    input  logic [TIME_WIDTH-1:0]  delta_time,
    input  logic [ID_WIDTH-1:0]    nb_id,
    input  logic [TIME_WIDTH-1:0]  nb_period,
    input  logic [TIME_WIDTH-1:0]  nb_remaining,
    output logic [ID_WIDTH-1:0]    id,
    output logic [TIME_WIDTH-1:0]  period,
    output logic [TIME_WIDTH-1:0]  remaining,
    output logic                   tick_zero
);

    logic [ID_WIDTH-1:0]   id_reg;
    logic [TIME_WIDTH-1:0] period_reg;
    logic [TIME_WIDTH-1:0] remaining_reg;
    logic [TIME_WIDTH-1:0] tick_rem;

    // saturate the countdown at zero
    assign tick_zero = (remaining_reg <= delta_time);
    assign tick_rem  = tick_zero ? '0 : (remaining_reg - delta_time);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            id_reg        <= new_id;
            period_reg    <= wait_time;
            remaining_reg <= wait_time;
        end
        else if (ctrl.shift)
        begin
            id_reg        <= nb_id;
            period_reg    <= nb_period;
            remaining_reg <= nb_remaining;
        end
        else if (ctrl.tick)
        begin
            remaining_reg <= tick_rem;
        end
        else if (ctrl.reload)
        begin
            remaining_reg <= period_reg;
        end
    end

    assign id        = id_reg;
    assign period    = period_reg;
    assign remaining = remaining_reg;

endmodule

### src/round_robin_countdown_task_queue_core.sv
// Round-robin countdown task queue.
// cmd channel (valid/ready): one command per transaction - add a task with
//   wait_time, tick the task at the serve cursor by delta_time, resolve the
//   ready task (finished removes it and closes the gap, otherwise its wait is
//   reloaded and the cursor advances), or cancel all tasks.
// rsp channel (valid/ready): exactly one response per command, carrying the
//   status, error code, new task id, ready task id and queue size after it.
// Latency: the response is valid in the cycle after the command is accepted.
// Throughput: one command per cycle; every command, the compacting remove
//   included, is done by one update of the row of task cells, each of which
//   loads, counts down, reloads or takes over its upper neighbor's entry.
// Stall: the response register holds while rsp.ready is low; cmd.ready stays
//   high while the register is empty or being drained in the same cycle, so
//   one command may be taken each cycle under a steady receiver.
// Reset: queue empty, status idle, cursor 0, next id 1, no response pending.
//   Task cells are not cleared; only entries below the count are ever read.
module round_robin_countdown_task_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32,
    parameter int ID_WIDTH    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rrcq_cmd_if.sink    cmd,
    rrcq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CUR_W = $clog2(QUEUE_DEPTH);

    logic [CNT_W-1:0]    count_reg,    count_next;
    logic [CUR_W-1:0]    cursor_reg,   cursor_next;
    logic [1:0]          status_reg,   status_next;
    logic [ID_WIDTH-1:0] ready_id_reg, ready_id_next;
    logic [ID_WIDTH-1:0] next_id_reg,  next_id_next;
    logic                rsp_valid_reg;
    logic [1:0]          error_reg,    error_next;
    logic [ID_WIDTH-1:0] new_id_reg,   new_id_next;

    logic fire;
    logic do_add, do_tick, do_remove, do_reload;
    logic sel_zero;
    logic [ID_WIDTH-1:0] sel_id;
    logic [ID_WIDTH-1:0] id_inc;

    rrcq_pkg::cell_ctrl_t  ctrl [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   cell_id   [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] cell_per  [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] cell_rem  [QUEUE_DEPTH];
    logic                  cell_zero [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   nb_id     [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] nb_per    [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] nb_rem    [QUEUE_DEPTH];

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = cmd.valid && cmd.ready;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            if (g < QUEUE_DEPTH - 1)
            begin : g_nb
                assign nb_id[g]  = cell_id[g+1];
                assign nb_per[g] = cell_per[g+1];
                assign nb_rem[g] = cell_rem[g+1];
            end
            else
            begin : g_top
                assign nb_id[g]  = '0;
                assign nb_per[g] = '0;
                assign nb_rem[g] = '0;
            end

            assign ctrl[g].load   = do_add && (count_reg == CNT_W'(g));
            assign ctrl[g].shift  = do_remove && (CNT_W'(g) >= CNT_W'(cursor_reg))
                                    && (CNT_W'(g + 1) < count_reg);
            assign ctrl[g].tick   = do_tick && (cursor_reg == CUR_W'(g));
            assign ctrl[g].reload = do_reload && (cursor_reg == CUR_W'(g));

            rrcq_cell #(
                .TIME_WIDTH (TIME_WIDTH),
                .ID_WIDTH   (ID_WIDTH)
            ) u_cell (
                .clk          (clk),
                .ctrl         (ctrl[g]),
                .new_id       (next_id_reg),
                .wait_time    (cmd.wait_time),
                .delta_time   (cmd.delta_time),
                .nb_id        (nb_id[g]),
                .nb_period    (nb_per[g]),
                .nb_remaining (nb_rem[g]),
                .id           (cell_id[g]),
                .period       (cell_per[g]),
                .remaining    (cell_rem[g]),
                .tick_zero    (cell_zero[g])
            );
        end
    endgenerate

    // pick the cell at the cursor
    always_comb
    begin
        sel_zero = 1'b0;
        sel_id   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cursor_reg == CUR_W'(i))
            begin
                sel_zero = sel_zero | cell_zero[i];
                sel_id   = sel_id | cell_id[i];
            end
        end
    end

    assign id_inc = next_id_reg + ID_WIDTH'(1);

    always_comb
    begin
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        status_next   = status_reg;
        ready_id_next = ready_id_reg;
        next_id_next  = next_id_reg;
        error_next    = rrcq_pkg::ERR_OK;
        new_id_next   = '0;
        do_add        = 1'b0;
        do_tick       = 1'b0;
        do_remove     = 1'b0;
        do_reload     = 1'b0;

        case (cmd.func)
            rrcq_pkg::FUNC_ADD:
            begin
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    error_next = rrcq_pkg::ERR_FULL;
                end
                else
                begin
                    do_add       = fire;
                    new_id_next  = next_id_reg;
                    count_next   = count_reg + CNT_W'(1);
                    next_id_next = (id_inc == '0) ? ID_WIDTH'(1) : id_inc;
                    if (status_reg == rrcq_pkg::ST_IDLE)
                        status_next = rrcq_pkg::ST_WAITING;
                end
            end
            rrcq_pkg::FUNC_TICK:
            begin
                if (status_reg == rrcq_pkg::ST_READY)
                begin
                    error_next = rrcq_pkg::ERR_TICK_READY;
                end
                else if (count_reg == '0)
                begin
                    status_next = rrcq_pkg::ST_IDLE;
                end
                else
                begin
                    do_tick = fire;
                    if (sel_zero)
                    begin
                        ready_id_next = sel_id;
                        status_next   = rrcq_pkg::ST_READY;
                    end
                    else
                    begin
                        status_next = rrcq_pkg::ST_WAITING;
                    end
                end
            end
            rrcq_pkg::FUNC_RESOLVE:
            begin
                if (status_reg != rrcq_pkg::ST_READY || count_reg == '0)
                begin
                    error_next = rrcq_pkg::ERR_NONE_READY;
                end
                else
                begin
                    ready_id_next = '0;
                    if (cmd.finished)
                    begin
                        do_remove  = fire;
                        count_next = count_reg - CNT_W'(1);
                        if (count_next == '0)
                        begin
                            cursor_next = '0;
                            status_next = rrcq_pkg::ST_IDLE;
                        end
                        else
                        begin
                            status_next = rrcq_pkg::ST_WAITING;
                            // removed the last entry: wrap to the front
                            if (CNT_W'(cursor_reg) == count_next)
                                cursor_next = '0;
                        end
                    end
                    else
                    begin
                        do_reload   = fire;
                        status_next = rrcq_pkg::ST_WAITING;
                        if (CNT_W'(cursor_reg) + CNT_W'(1) == count_reg)
                            cursor_next = '0;
                        else
                            cursor_next = cursor_reg + CUR_W'(1);
                    end
                end
            end
            default:
            begin
                count_next    = '0;
                cursor_next   = '0;
                ready_id_next = '0;
                status_next   = rrcq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            status_reg    <= rrcq_pkg::ST_IDLE;
            ready_id_reg  <= '0;
            next_id_reg   <= ID_WIDTH'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                cursor_reg    <= cursor_next;
                status_reg    <= status_next;
                ready_id_reg  <= ready_id_next;
                next_id_reg   <= next_id_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            error_reg  <= error_next;
            new_id_reg <= new_id_next;
        end
    end

    // state registers update only on a transaction, so they hold under stall
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.error         = error_reg;
    assign rsp.new_task_id   = new_id_reg;
    assign rsp.ready_task_id = ready_id_reg;
    assign rsp.queue_size    = count_reg;

endmodule

### src/rrcq_checker.sv
module rrcq_checker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 32,
    parameter int SIZE_WIDTH  = 5
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [1:0]            rsp_status,
    input logic [1:0]            rsp_error,
    input logic [ID_WIDTH-1:0]   rsp_new_task_id,
    input logic [SIZE_WIDTH-1:0] rsp_queue_size
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error)
            && $stable(rsp_new_task_id) && $stable(rsp_queue_size) && $stable(rsp_status))
        else $error("response changed while stalled");

    a_cmd_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
        else $error("accepted command produced no response");

    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("command taken while response stalled");

    a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_error == rrcq_pkg::ERR_FULL
            |-> rsp_queue_size == SIZE_WIDTH'(QUEUE_DEPTH) && rsp_new_task_id == '0)
        else $error("queue full reported with room left");

    a_err_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_error != rrcq_pkg::ERR_OK |-> rsp_new_task_id == '0)
        else $error("new id given on an error");

endmodule

bind round_robin_countdown_task_queue_core rrcq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .SIZE_WIDTH  ($clog2(QUEUE_DEPTH + 1))
) u_rrcq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_error       (rsp.error),
    .rsp_new_task_id (rsp.new_task_id),
    .rsp_queue_size  (rsp.queue_size)
);

### tb/task_queue_tracker.sv
module task_queue_tracker
    import rrcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    rrcq_cmd_if  cmd,
    rrcq_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  err;
        logic [31:0] new_id;
        logic [31:0] rdy_id;
        logic [4:0]  size;
    } queue_reply_t;

    // Own copy of the task store, the cursor and the queue status.
    logic [31:0]  id_mem     [QUEUE_DEPTH];
    logic [31:0]  period_mem [QUEUE_DEPTH];
    logic [31:0]  left_mem   [QUEUE_DEPTH];
    int           held;
    int           cursor;
    logic [1:0]   q_status;
    logic [31:0]  cur_ready_id;
    logic [31:0]  id_next;
    int           fails;
    queue_reply_t replies_due[$];

    function automatic void clear_queue_state();
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            id_mem[k]     = '0;
            period_mem[k] = '0;
            left_mem[k]   = '0;
        end
        held         = 0;
        cursor       = 0;
        q_status     = ST_IDLE;
        cur_ready_id = '0;
        id_next      = 32'd1;
    endfunction

    function automatic queue_reply_t apply_command(logic [1:0] f, logic [31:0] w,
                                                   logic [31:0] d, logic fin);
        queue_reply_t r;
        r.err    = ERR_OK;
        r.new_id = '0;
        case (f)
            FUNC_ADD:
            begin
                if (held >= QUEUE_DEPTH)
                begin
                    r.err = ERR_FULL;
                end
                else
                begin
                    id_mem[held]     = id_next;
                    period_mem[held] = w;
                    left_mem[held]   = w;
                    held++;
                    r.new_id = id_next;
                    // skip id 0 on wrap, it means "none"
                    id_next++;
                    if (id_next == '0)
                        id_next = 32'd1;
                    if (q_status == ST_IDLE)
                        q_status = ST_WAITING;
                end
            end
            FUNC_TICK:
            begin
                if (q_status == ST_READY)
                begin
                    r.err = ERR_TICK_READY;
                end
                else if (held == 0)
                begin
                    q_status = ST_IDLE;
                end
                else
                begin
                    cursor = cursor % held;
                    // saturate the countdown at zero
                    left_mem[cursor] = (left_mem[cursor] > d) ? left_mem[cursor] - d : '0;
                    if (left_mem[cursor] == '0)
                    begin
                        cur_ready_id = id_mem[cursor];
                        q_status     = ST_READY;
                    end
                    else
                    begin
                        q_status = ST_WAITING;
                    end
                end
            end
            FUNC_RESOLVE:
            begin
                if (q_status != ST_READY || held == 0)
                begin
                    r.err = ERR_NONE_READY;
                end
                else
                begin
                    cursor = cursor % held;
                    if (fin)
                    begin
                        // close the gap left by the finished task
                        for (int k = cursor; k + 1 < held; k++)
                        begin
                            id_mem[k]     = id_mem[k + 1];
                            period_mem[k] = period_mem[k + 1];
                            left_mem[k]   = left_mem[k + 1];
                        end
                        held--;
                    end
                    else
                    begin
                        left_mem[cursor] = period_mem[cursor];
                        cursor++;
                    end
                    cur_ready_id = '0;
                    if (held == 0)
                    begin
                        cursor   = 0;
                        q_status = ST_IDLE;
                    end
                    else
                    begin
                        cursor   = cursor % held;
                        q_status = ST_WAITING;
                    end
                end
            end
            default:
            begin
                held         = 0;
                cursor       = 0;
                cur_ready_id = '0;
                q_status     = ST_IDLE;
            end
        endcase
        r.status = q_status;
        r.rdy_id = cur_ready_id;
        r.size   = held[4:0];
        return r;
    endfunction

    function automatic void report_mismatch(string what, queue_reply_t want, queue_reply_t got);
        fails++;
        if (fails <= 10)
            $display("%0t: %s: exp status=%0d err=%0d new_id=%0h ready_id=%0h size=%0d",
                     $realtime, what, want.status, want.err, want.new_id, want.rdy_id,
                     want.size,
                     "\n    got status=%0d err=%0d new_id=%0h ready_id=%0h size=%0d",
                     got.status, got.err, got.new_id, got.rdy_id, got.size);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_reply_t got;
        queue_reply_t want;
        if (!rst_n)
        begin
            clear_queue_state();
            replies_due.delete();
            fails = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // retire the oldest expectation before taking a new command
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.status, rsp.error, rsp.new_task_id, rsp.ready_task_id,
                        rsp.queue_size};
                if (replies_due.size() == 0)
                begin
                    report_mismatch("response with no command pending", '0, got);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status || got.err !== want.err ||
                        got.new_id !== want.new_id || got.rdy_id !== want.rdy_id ||
                        got.size !== want.size)
                        report_mismatch("response mismatch", want, got);
                end
            end
            if (cmd.valid && cmd.ready)
                replies_due.insert(replies_due.size(),
                                   apply_command(cmd.func, cmd.wait_time, cmd.delta_time,
                                                 cmd.finished));
            fail_count <= fails;
            pending    <= replies_due.size();
        end
    end

endmodule

### tb/tb_round_robin_countdown_task_queue_core.sv
module tb_round_robin_countdown_task_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rrcq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TOTAL_CMDS   = 1550;
    localparam int CALM_CMDS    = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    int   issued;
    int   gap_pct;
    int   stall_pct;
    bit   quiet;
    bit   hold_req;

    rrcq_cmd_if #(.TIME_WIDTH(32)) cmd_ch ();
    rrcq_rsp_if #(.ID_WIDTH(32), .SIZE_WIDTH(5)) rsp_ch ();

    round_robin_countdown_task_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TIME_WIDTH (32),
        .ID_WIDTH   (32)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch)
    );

    task_queue_tracker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_idle_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 15;
            default: return 35;
        endcase
    endfunction

    function automatic logic [31:0] pick_wait();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        else if (r < 65)
            return $urandom_range(1, 24);
        else if (r < 80)
            return $urandom();
        else if (r < 90)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            return $urandom_range(1, 1000);
    endfunction

    function automatic logic [31:0] pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        else if (r < 70)
            return $urandom_range(1, 12);
        else if (r < 85)
            return $urandom();
        else
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endfunction

    // Offer one command and hold it until the queue takes the transaction.
    task automatic issue(input logic [1:0] f, input logic [31:0] w, input logic [31:0] d,
                         input logic fin);
        int gap;
        gap = 0;
        quiet = (issued >= TOTAL_CMDS - CALM_CMDS);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= f;
        cmd_ch.wait_time  <= w;
        cmd_ch.delta_time <= d;
        cmd_ch.finished   <= fin;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        issued++;
    endtask

    task automatic issue_random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            issue(FUNC_ADD, pick_wait(), $urandom(), $urandom_range(0, 1));
        else if (r < 65)
            issue(FUNC_TICK, $urandom(), pick_delta(), $urandom_range(0, 1));
        else if (r < 97)
            issue(FUNC_RESOLVE, $urandom(), $urandom(), $urandom_range(0, 1));
        else
            issue(FUNC_CANCEL, $urandom(), $urandom(), $urandom_range(0, 1));
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial
    begin
        int stall_left;
        int hold_left;
        int stretch;
        stall_left = 0;
        hold_left  = 0;
        stretch    = 0;
        stall_pct  = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                stretch   = $urandom_range(50, 300);
                stall_pct = pick_idle_rate();
            end
            stretch--;
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int  kind;
        bit  held_off;
        cycles            = 0;
        issued            = 0;
        quiet             = 1'b0;
        hold_req          = 1'b0;
        held_off          = 1'b0;
        gap_pct           = 15;
        cmd_ch.valid      = 1'b0;
        cmd_ch.func       = FUNC_ADD;
        cmd_ch.wait_time  = '0;
        cmd_ch.delta_time = '0;
        cmd_ch.finished   = 1'b0;
        rst_n             = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tick and resolve on an empty queue
        issue(FUNC_TICK, '0, 32'd1, 1'b0);
        issue(FUNC_RESOLVE, '0, '0, 1'b1);
        // zero and maximal periods, then a zero tick makes the first task ready
        issue(FUNC_ADD, '0, '0, 1'b0);
        issue(FUNC_ADD, 32'hFFFF_FFFF, '0, 1'b0);
        issue(FUNC_TICK, '0, '0, 1'b0);
        issue(FUNC_TICK, '0, 32'd3, 1'b0);
        issue(FUNC_ADD, 32'd3, '0, 1'b0);
        // reload and advance, then a maximal tick drains the long task
        issue(FUNC_RESOLVE, '0, '0, 1'b0);
        issue(FUNC_TICK, '0, 32'hFFFF_FFFF, 1'b0);
        issue(FUNC_RESOLVE, '0, '0, 1'b1);
        issue(FUNC_RESOLVE, '0, '0, 1'b0);
        // countdown underflow saturates at zero
        issue(FUNC_TICK, '0, 32'd5, 1'b0);
        // fill to the limit and overflow once while ready
        repeat (QUEUE_DEPTH - 1)
            issue(FUNC_ADD, $urandom_range(1, 8), '0, 1'b0);
        issue(FUNC_TICK, '0, 32'd1, 1'b0);
        issue(FUNC_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        while (issued < TOTAL_CMDS)
        begin
            gap_pct = pick_idle_rate();
            if (!held_off && issued > 400)
            begin
                held_off = 1'b1;
                hold_req = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                repeat ($urandom_range(14, 19))
                    issue(FUNC_ADD, pick_wait(), $urandom(), $urandom_range(0, 1));
            end
            else if (kind < 30)
            begin
                repeat ($urandom_range(6, 12))
                begin
                    issue(FUNC_TICK, $urandom(), pick_delta(), $urandom_range(0, 1));
                    issue(FUNC_RESOLVE, $urandom(), $urandom(), $urandom_range(0, 1));
                end
            end
            else
            begin
                repeat ($urandom_range(10, 30))
                    issue_random_op();
            end
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
src/rrcq_pkg.sv
src/rrcq_cmd_if.sv
src/rrcq_rsp_if.sv
src/rrcq_cell.sv
src/round_robin_countdown_task_queue_core.sv
src/rrcq_checker.sv
tb/task_queue_tracker.sv
tb/tb_round_robin_countdown_task_queue_core.sv
